// ----- rtl/sensor_poll_frame_scheduler_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SENSOR_POLL_FRAME_SCHEDULER_MACROS_SVH
`define SENSOR_POLL_FRAME_SCHEDULER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SPFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/spfs_pkg.sv -----
// Package with shared types and constants of the frame scheduler.
package spfs_pkg;
	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_POLL  = 2'd1,
		ACT_END   = 2'd2,
		ACT_END2  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_FAILED   = 3'd0,
		REG_TEMP_EV  = 3'd1,
		REG_MISS_LIM = 3'd2,
		REG_CMD_SENS = 3'd3,
		REG_CMD_COMB = 3'd4
	} reg_idx_t;

	localparam int ST_INIT     = 0;
	localparam int ST_LATE     = 1;
	localparam int ST_SPI      = 2;
	localparam int ST_SENSOR   = 3;
	localparam int ST_NOTFRESH = 4;

	localparam logic [15:0] TEMP_INVALID  = 16'h8000;
	localparam logic [23:0] PRESS_INVALID = 24'h800000;

	typedef struct packed {
		action_t     action;
		logic [3:0]  channel;
		logic        budget_expired;
		logic        status_read_ok;
		logic [7:0]  ready_byte;
		logic        measure_read_ok;
		logic [15:0] temp_raw;
		logic [23:0] pressure_raw;
	} item_t;

	typedef struct packed {
		logic [3:0]  channel_out;
		logic        trigger;
		logic [7:0]  trigger_command;
		logic        fresh;
		logic [15:0] temperature;
		logic [23:0] pressure;
		logic [4:0]  frame_status;
		logic [15:0] fresh_set;
		logic        all_fresh;
	} result_t;
endpackage

// ----- rtl/spfs_front.sv -----
// Front part: input register stage in front of the executor.
module spfs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  spfs_pkg::item_t item_in,
	output logic            valid_s1,
	output spfs_pkg::item_t item_s1,
	input  logic            take
);
	assign full = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= item_in;
		end
	end
endmodule

// ----- rtl/spfs_back.sv -----
// Back part: state update and result build for one item per cycle while the result register is not held.
module spfs_back #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  spfs_pkg::item_t   item_s1,
	output logic              take,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [15:0]       cfg_data,
	output logic              res_valid_q,
	output spfs_pkg::result_t res_q,
	input  logic              pop
);
	localparam logic [15:0] CMASK = (CHANNELS >= 16) ? 16'hFFFF :
		16'((32'd1 << CHANNELS) - 32'd1);

	logic [15:0] failed_q;
	logic [7:0]  temp_every_q, miss_limit_q, cmd_sens_q, cmd_comb_q;
	logic [7:0]  phase_q, cmd_q;
	logic [4:0]  status_q;
	logic [15:0] fresh_q;
	logic        stopped_q;
	logic [15:0] tvalid_q;
	logic [15:0] temp_q [16];
	logic [23:0] press_q [16];
	logic [7:0]  miss_q [16];

	logic [3:0]  ch;
	logic        chv;
	logic [8:0]  ph_inc;
	logic signed [20:0] tmul;
	logic signed [20:0] tdiv;
	logic        pneg;
	logic [23:0] pmag;
	logic [27:0] pm9;
	logic [22:0] p16;
	logic [46:0] pq_full;
	logic [20:0] pq;
	logic [7:0]  miss_inc;
	spfs_pkg::result_t r;
	logic [4:0]  st_n;
	logic [15:0] fr_n;
	logic        stop_n, store, clr_miss, inc_miss;
	logic [15:0] t_st;
	logic [23:0] p_st;

	assign take = !res_valid_q || pop;
	assign ch = item_s1.channel;
	assign chv = (32'(ch) < CHANNELS);
	assign ph_inc = {1'b0, phase_q} + 9'd1;
	assign tmul = 21'(signed'(item_s1.temp_raw)) * 21'sd10;
	assign tdiv = tmul / 21'sd256;

	// Pressure is scaled on its magnitude so that the quotient truncates toward zero;
	// the division by eighty is a shift by four and a reciprocal multiply for five.
	assign pneg = item_s1.pressure_raw[23];
	assign pmag = pneg ? (-item_s1.pressure_raw) : item_s1.pressure_raw;
	assign pm9 = {4'b0, pmag} + {1'b0, pmag, 3'b0};
	assign p16 = pm9[26:4];
	assign pq_full = {24'd0, p16} * {23'd0, 24'hCCCCCD};
	assign pq = pq_full[46:26];

	assign miss_inc = (miss_q[ch] == 8'hFF) ? 8'hFF : miss_q[ch] + 8'd1;

	always_comb begin
		r = '0;
		st_n = status_q;
		fr_n = fresh_q;
		stop_n = stopped_q;
		store = 1'b0;
		clr_miss = 1'b0;
		inc_miss = 1'b0;
		t_st = 16'(tdiv);
		p_st = pneg ? (-{3'b0, pq}) : {3'b0, pq};
		unique case (item_s1.action)
			spfs_pkg::ACT_BEGIN: begin
				fr_n = '0;
				stop_n = 1'b0;
				st_n = '0;
				st_n[spfs_pkg::ST_INIT] = |(failed_q & CMASK);
				r.trigger_command = (phase_q == 8'd0) ? cmd_comb_q : cmd_sens_q;
			end
			spfs_pkg::ACT_POLL: begin
				r.channel_out = ch;
				if (chv && !stopped_q && item_s1.budget_expired) begin
					st_n[spfs_pkg::ST_LATE] = 1'b1;
					stop_n = 1'b1;
				end else if (chv && !stopped_q && !failed_q[ch]) begin
					if (!item_s1.status_read_ok) begin
						st_n[spfs_pkg::ST_SPI] = 1'b1;
					end else if (|item_s1.ready_byte[7:2]) begin
						st_n[spfs_pkg::ST_SENSOR] = 1'b1;
					end else if (item_s1.ready_byte[0]) begin
						if (!item_s1.measure_read_ok) begin
							st_n[spfs_pkg::ST_SPI] = 1'b1;
						end else begin
							store = 1'b1;
							clr_miss = 1'b1;
							fr_n[ch] = 1'b1;
							r.fresh = 1'b1;
							r.trigger = 1'b1;
						end
					end else if (miss_inc >= miss_limit_q) begin
						r.trigger = 1'b1;
						clr_miss = 1'b1;
					end else begin
						inc_miss = 1'b1;
					end
				end
				if (chv) begin
					if (store) begin
						r.temperature = t_st;
						r.pressure = p_st;
					end else if (tvalid_q[ch]) begin
						r.temperature = temp_q[ch];
						r.pressure = press_q[ch];
					end else begin
						r.temperature = spfs_pkg::TEMP_INVALID;
						r.pressure = spfs_pkg::PRESS_INVALID;
					end
				end
				r.trigger_command = cmd_q;
			end
			spfs_pkg::ACT_END, spfs_pkg::ACT_END2: begin
				if ((fresh_q & CMASK) != CMASK) begin
					st_n[spfs_pkg::ST_NOTFRESH] = 1'b1;
				end else begin
					r.all_fresh = 1'b1;
				end
				r.trigger_command = cmd_q;
			end
			default: ;
		endcase
		r.frame_status = st_n;
		r.fresh_set = fr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= '0;
			temp_every_q <= 8'd10;
			miss_limit_q <= 8'd3;
			cmd_sens_q <= '0;
			cmd_comb_q <= '0;
			phase_q <= '0;
			cmd_q <= '0;
			status_q <= '0;
			fresh_q <= '0;
			stopped_q <= 1'b0;
			tvalid_q <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				miss_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					spfs_pkg::REG_FAILED:   failed_q <= cfg_data;
					spfs_pkg::REG_TEMP_EV:  temp_every_q <= cfg_data[7:0];
					spfs_pkg::REG_MISS_LIM: miss_limit_q <= cfg_data[7:0];
					spfs_pkg::REG_CMD_SENS: cmd_sens_q <= cfg_data[7:0];
					spfs_pkg::REG_CMD_COMB: cmd_comb_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (take) begin
				res_valid_q <= valid_s1;
			end
			if (valid_s1 && take) begin
				status_q <= st_n;
				fresh_q <= fr_n;
				stopped_q <= stop_n;
				if (item_s1.action == spfs_pkg::ACT_BEGIN) begin
					cmd_q <= r.trigger_command;
					phase_q <= (ph_inc >= {1'b0, temp_every_q}) ? 8'd0 : ph_inc[7:0];
				end
				if (store) begin
					tvalid_q[ch] <= 1'b1;
				end
				if (clr_miss) begin
					miss_q[ch] <= '0;
				end else if (inc_miss) begin
					miss_q[ch] <= miss_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take) begin
			res_q <= r;
			if (store) begin
				temp_q[ch] <= t_st;
				press_q[ch] <= p_st;
			end
		end
	end
endmodule

// ----- rtl/sensor_poll_frame_scheduler.sv -----
// Top level of the sensor poll frame scheduler.
// A pushed item passes the input stage register and then the result register before it shows as a result.
// Throughput: one item per cycle while pop keeps the result register from being held.
// Full rises only when the result register and the input stage both hold data and pop is low.
// Reset is asynchronous and active low; it restores register defaults.
// Stored values read as the invalid markers until a channel is first written.
module sensor_poll_frame_scheduler #(
	parameter int CHANNELS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [3:0]         channel,
	input  logic               budget_expired,
	input  logic               status_read_ok,
	input  logic [7:0]         ready_byte,
	input  logic               measure_read_ok,
	input  logic signed [15:0] temp_raw,
	input  logic [23:0]        pressure_raw,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         channel_out,
	output logic               trigger,
	output logic [7:0]         trigger_command,
	output logic               fresh,
	output logic signed [15:0] temperature,
	output logic signed [23:0] pressure,
	output logic [4:0]         frame_status,
	output logic [15:0]        fresh_set,
	output logic               all_fresh,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_data
);
	spfs_pkg::item_t   item_in, item_s1;
	spfs_pkg::result_t res_q;
	logic valid_s1, take, res_valid_q;

	assign item_in = '{action: spfs_pkg::action_t'(action), channel: channel,
		budget_expired: budget_expired, status_read_ok: status_read_ok,
		ready_byte: ready_byte, measure_read_ok: measure_read_ok,
		temp_raw: temp_raw, pressure_raw: pressure_raw};

	spfs_front u_front (.clk, .arst_n, .push, .full, .item_in, .valid_s1,
		.item_s1, .take);

	spfs_back #(.CHANNELS(CHANNELS)) u_back (.clk, .arst_n, .valid_s1, .item_s1,
		.take, .cfg_we, .cfg_idx, .cfg_data, .res_valid_q, .res_q, .pop);

	assign empty = !res_valid_q;
	assign channel_out = res_q.channel_out;
	assign trigger = res_q.trigger;
	assign trigger_command = res_q.trigger_command;
	assign fresh = res_q.fresh;
	assign temperature = res_q.temperature;
	assign pressure = res_q.pressure;
	assign frame_status = res_q.frame_status;
	assign fresh_set = res_q.fresh_set;
	assign all_fresh = res_q.all_fresh;
endmodule

// ----- rtl/spfs_checker.sv -----
// Port checker for the frame scheduler and its bind.
`include "sensor_poll_frame_scheduler_macros.svh"
module spfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        fresh,
	input logic        trigger,
	input logic [15:0] fresh_set
);
	`SPFS_ASSERT_IMP(a_fresh_trig, clk, arst_n, !empty && fresh, trigger)
	`SPFS_ASSERT_IMP(a_full_busy, clk, arst_n, full, !empty)
	`SPFS_ASSERT_NXT(a_push_lands, clk, arst_n, push && !full && empty, ##1 !empty)
	`SPFS_ASSERT_IMP(a_fresh_set, clk, arst_n, !empty && fresh, fresh_set != 16'd0)
endmodule

bind sensor_poll_frame_scheduler spfs_checker u_chk (.clk, .arst_n, .push, .full,
	.empty, .pop, .fresh, .trigger, .fresh_set);

// ----- bench/tb_sensor_poll_frame_scheduler.sv -----
// Testbench for the sensor poll frame scheduler, checked against a predictor.
`timescale 1ns / 1ps

module tb_sensor_poll_frame_scheduler;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	spfs_pkg::item_t drv = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;
	spfs_pkg::result_t got;

	// Predictor state and configuration copy.
	logic [15:0] cfg_failed = 16'd0;
	logic [7:0] cfg_temp_every = 8'd10;
	logic [7:0] cfg_miss_limit = 8'd3;
	logic [7:0] cfg_cmd_sensor = 8'd0;
	logic [7:0] cfg_cmd_combined = 8'd0;
	logic [7:0] phase_ctr = '0;
	logic [7:0] frame_cmd = '0;
	logic [15:0] temp_store [16];
	logic [23:0] press_store [16];
	logic [7:0] miss_ctr [16];
	logic [4:0] status_acc = '0;
	logic [15:0] fresh_acc = '0;
	logic sweep_halted = 1'b0;

	spfs_pkg::result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int hold_req = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	sensor_poll_frame_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(drv.action), .channel(drv.channel), .budget_expired(drv.budget_expired),
		.status_read_ok(drv.status_read_ok), .ready_byte(drv.ready_byte),
		.measure_read_ok(drv.measure_read_ok), .temp_raw(drv.temp_raw),
		.pressure_raw(drv.pressure_raw), .empty(empty), .pop(pop),
		.channel_out(got.channel_out), .trigger(got.trigger),
		.trigger_command(got.trigger_command), .fresh(got.fresh),
		.temperature(got.temperature), .pressure(got.pressure),
		.frame_status(got.frame_status), .fresh_set(got.fresh_set),
		.all_fresh(got.all_fresh),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < 16; i++) begin
			temp_store[i] = spfs_pkg::TEMP_INVALID;
			press_store[i] = spfs_pkg::PRESS_INVALID;
			miss_ctr[i] = '0;
		end
	end

	function automatic spfs_pkg::result_t schedule_step(spfs_pkg::item_t it);
		spfs_pkg::result_t r;
		logic [15:0] chbit;
		logic [3:0] ch;
		int t;
		int p;
		r = '0;
		ch = it.channel;
		chbit = 16'd1 << ch;
		case (it.action)
			spfs_pkg::ACT_BEGIN: begin
				frame_cmd = (phase_ctr == 8'd0) ? cfg_cmd_combined : cfg_cmd_sensor;
				phase_ctr = (int'(phase_ctr) + 1 >= int'(cfg_temp_every)) ? 8'd0 :
					phase_ctr + 8'd1;
				fresh_acc = '0;
				sweep_halted = 1'b0;
				status_acc = '0;
				status_acc[spfs_pkg::ST_INIT] = (cfg_failed != 16'd0);
			end
			spfs_pkg::ACT_POLL: begin
				if (!sweep_halted && it.budget_expired) begin
					status_acc[spfs_pkg::ST_LATE] = 1'b1;
					sweep_halted = 1'b1;
				end else if (!sweep_halted && (cfg_failed & chbit) == 16'd0) begin
					if (!it.status_read_ok) begin
						status_acc[spfs_pkg::ST_SPI] = 1'b1;
					end else if (it.ready_byte[7:2] != 6'd0) begin
						status_acc[spfs_pkg::ST_SENSOR] = 1'b1;
					end else if (it.ready_byte[0]) begin
						if (!it.measure_read_ok) begin
							status_acc[spfs_pkg::ST_SPI] = 1'b1;
						end else begin
							t = $signed(it.temp_raw);
							p = $signed(it.pressure_raw);
							temp_store[ch] = 16'((t * 10) / 256);
							press_store[ch] = 24'((p * 9) / 80);
							fresh_acc |= chbit;
							miss_ctr[ch] = '0;
							r.fresh = 1'b1;
							r.trigger = 1'b1;
						end
					end else begin
						if (miss_ctr[ch] < 8'hFF) miss_ctr[ch]++;
						if (miss_ctr[ch] >= cfg_miss_limit) begin
							r.trigger = 1'b1;
							miss_ctr[ch] = '0;
						end
					end
				end
				r.channel_out = ch;
				r.temperature = temp_store[ch];
				r.pressure = press_store[ch];
			end
			default: begin
				if (fresh_acc != 16'hFFFF) status_acc[spfs_pkg::ST_NOTFRESH] = 1'b1;
				else r.all_fresh = 1'b1;
			end
		endcase
		r.trigger_command = frame_cmd;
		r.frame_status = status_acc;
		r.fresh_set = fresh_acc;
		return r;
	endfunction

	task automatic check_field(string name, longint exp, longint act);
		if (exp != act) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
			errors++;
		end
	endtask

	// Accepted transfers on both sides, and configuration writes.
	always @(posedge clk) begin
		spfs_pkg::result_t e;
		if (arst_n) begin
			if (cfg_we) begin
				case (spfs_pkg::reg_idx_t'(cfg_idx))
					spfs_pkg::REG_FAILED:   cfg_failed = cfg_data;
					spfs_pkg::REG_TEMP_EV:  cfg_temp_every = cfg_data[7:0];
					spfs_pkg::REG_MISS_LIM: cfg_miss_limit = cfg_data[7:0];
					spfs_pkg::REG_CMD_SENS: cfg_cmd_sensor = cfg_data[7:0];
					spfs_pkg::REG_CMD_COMB: cfg_cmd_combined = cfg_data[7:0];
					default: ;
				endcase
			end
			if (push && !full) pending_results.push_back(schedule_step(drv));
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %0h", $time, got);
					errors++;
				end else begin
					e = pending_results.pop_front();
					check_field("channel_out", e.channel_out, got.channel_out);
					check_field("trigger", e.trigger, got.trigger);
					check_field("trigger_command", e.trigger_command, got.trigger_command);
					check_field("fresh", e.fresh, got.fresh);
					check_field("temperature", e.temperature, got.temperature);
					check_field("pressure", e.pressure, got.pressure);
					check_field("frame_status", e.frame_status, got.frame_status);
					check_field("fresh_set", e.fresh_set, got.fresh_set);
					check_field("all_fresh", e.all_fresh, got.all_fresh);
				end
			end
		end
	end

	// Receiver with random stalls and an optional long hold-off.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_req > 0) begin
			pop <= 1'b0;
			hold_req--;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
			if (!quiet && r < 20) stall_left = $urandom_range(1, 3);
			else if (!quiet && r < 23) stall_left = $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_item(spfs_pkg::item_t it);
		int r;
		int gap;
		push <= 1'b1;
		drv <= it;
		do @(posedge clk); while (full);
		items_sent++;
		r = $urandom_range(0, 99);
		gap = 0;
		if (!quiet && r < 25) gap = $urandom_range(1, 3);
		else if (!quiet && r < 28) gap = $urandom_range(10, 30);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(spfs_pkg::reg_idx_t idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] failed, logic [7:0] every, logic [7:0] lim,
			logic [7:0] cs, logic [7:0] cc);
		write_reg(spfs_pkg::REG_FAILED, failed);
		write_reg(spfs_pkg::REG_TEMP_EV, {8'd0, every});
		write_reg(spfs_pkg::REG_MISS_LIM, {8'd0, lim});
		write_reg(spfs_pkg::REG_CMD_SENS, {8'd0, cs});
		write_reg(spfs_pkg::REG_CMD_COMB, {8'd0, cc});
	endtask

	function automatic spfs_pkg::item_t mk(spfs_pkg::action_t a, logic [3:0] ch, logic be,
			logic sok, logic [7:0] rdy, logic mok, logic [15:0] t, logic [23:0] p);
		spfs_pkg::item_t it;
		it.action = a;
		it.channel = ch;
		it.budget_expired = be;
		it.status_read_ok = sok;
		it.ready_byte = rdy;
		it.measure_read_ok = mok;
		it.temp_raw = t;
		it.pressure_raw = p;
		return it;
	endfunction

	function automatic spfs_pkg::item_t rnd_poll(logic [3:0] ch);
		int r;
		logic [7:0] rdy;
		r = $urandom_range(0, 99);
		if (r < 60) rdy = 8'h01;
		else if (r < 85) rdy = 8'h00;
		else rdy = 8'($urandom);
		return mk(spfs_pkg::ACT_POLL, ch, 1'b0, $urandom_range(0, 19) != 0, rdy,
			$urandom_range(0, 19) != 0, 16'($urandom), 24'($urandom));
	endfunction

	function automatic spfs_pkg::item_t rnd_noise();
		spfs_pkg::item_t it;
		it = spfs_pkg::item_t'(57'({$urandom, $urandom}));
		return it;
	endfunction

	// One frame: begin, polls over the channels with the odd skip, maybe a
	// late sweep and a noise item, then end.
	task automatic run_frame();
		spfs_pkg::item_t it;
		int late_at;
		late_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : -1;
		send_item(mk(spfs_pkg::ACT_BEGIN, 4'($urandom), 1'b0, 1'b0, 8'd0, 1'b0, 16'd0, 24'd0));
		for (int c = 0; c < 16; c++) begin
			if ($urandom_range(0, 19) == 0) continue;
			it = rnd_poll(4'(c));
			if (c == late_at) it.budget_expired = 1'b1;
			send_item(it);
		end
		if ($urandom_range(0, 3) == 0) send_item(rnd_noise());
		send_item(mk($urandom_range(0, 3) == 0 ? spfs_pkg::ACT_END2 : spfs_pkg::ACT_END,
			4'($urandom), 1'b0, 1'b0, 8'd0, 1'b0, 16'd0, 24'd0));
	endtask

	task automatic test_before_first_frame();
		send_item(mk(spfs_pkg::ACT_POLL, 4'd5, 1'b0, 1'b1, 8'h01, 1'b1, 16'h7FFF, 24'h7FFFFF));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd6, 1'b0, 1'b1, 8'h00, 1'b1, 16'h0, 24'h0));
		send_item(mk(spfs_pkg::ACT_END, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
	endtask

	task automatic test_special_cases();
		set_config(16'h0000, 8'd2, 8'd0, 8'hA5, 8'h5A);
		send_item(mk(spfs_pkg::ACT_BEGIN, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd0, 1'b0, 1'b1, 8'h01, 1'b1, 16'h7FFF, 24'h7FFFFF));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd1, 1'b0, 1'b1, 8'h01, 1'b1, 16'h8000, 24'h800000));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd2, 1'b0, 1'b1, 8'h01, 1'b1, 16'hFFFF, 24'hFFFFFF));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd3, 1'b0, 1'b0, 8'h01, 1'b1, 16'h1234, 24'h1));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd3, 1'b0, 1'b1, 8'hFD, 1'b1, 16'h1234, 24'h1));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd3, 1'b0, 1'b1, 8'h01, 1'b0, 16'h1234, 24'h1));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd4, 1'b0, 1'b1, 8'h00, 1'b1, 16'h0, 24'h0));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd15, 1'b1, 1'b1, 8'h01, 1'b1, 16'h0100, 24'h50));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd14, 1'b0, 1'b1, 8'h01, 1'b1, 16'h0100, 24'h50));
		send_item(mk(spfs_pkg::ACT_END2, 4'd9, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
		send_item(mk(spfs_pkg::ACT_BEGIN, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
		for (int c = 0; c < 16; c++)
			send_item(mk(spfs_pkg::ACT_POLL, 4'(c), 1'b0, 1'b1, 8'h01, 1'b1, 16'(c * 77),
				24'(c * 999)));
		send_item(mk(spfs_pkg::ACT_END, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
		set_config(16'hFFFF, 8'd255, 8'd255, 8'h00, 8'hFF);
		send_item(mk(spfs_pkg::ACT_BEGIN, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
		send_item(mk(spfs_pkg::ACT_POLL, 4'd7, 1'b0, 1'b1, 8'h01, 1'b1, 16'h4000, 24'h400000));
		send_item(mk(spfs_pkg::ACT_END, 4'd0, 1'b0, 1'b0, 8'h0, 1'b0, 16'h0, 24'h0));
	endtask

	task automatic test_config_sweep();
		set_config(16'h8001, 8'd1, 8'd1, 8'h11, 8'h22);
		repeat (3) run_frame();
		set_config(16'h0000, 8'd3, 8'd2, 8'hFF, 8'h00);
		repeat (4) run_frame();
		set_config(16'h0000, 8'd0, 8'd4, 8'h3C, 8'hC3);
		repeat (3) run_frame();
		set_config(16'h0000, 8'd2, 8'd1, 8'h96, 8'h69);
		repeat (2) run_frame();
	endtask

	task automatic test_backpressure();
		drain();
		hold_req = 300;
		repeat (3) run_frame();
	endtask

	task automatic test_random();
		int target;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 19) == 0) begin
				set_config(16'($urandom) & ($urandom_range(0, 1) ? 16'h0 : 16'hFFFF),
					8'($urandom_range(1, 12)), 8'($urandom_range(0, 6)),
					8'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) send_item(rnd_noise());
			end else begin
				run_frame();
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_first_frame();
		test_special_cases();
		test_config_sweep();
		test_backpressure();
		test_random();
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ----- sensor_poll_frame_scheduler.f -----
+incdir+rtl
rtl/spfs_pkg.sv
rtl/spfs_front.sv
rtl/spfs_back.sv
rtl/sensor_poll_frame_scheduler.sv
rtl/spfs_checker.sv
bench/tb_sensor_poll_frame_scheduler.sv
